// ===== hw/rtl/solid_border_node_finder_macros.svh =====
// Assertion helpers for the border node finder.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef SOLID_BORDER_NODE_FINDER_MACROS_SVH
`define SOLID_BORDER_NODE_FINDER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SBNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SBNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sbnf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbnf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COORD_W   = 10;
  localparam int DIM_W     = 11;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W = 2;
  localparam int NCAND     = 4;
  localparam int SLOT_W    = $clog2(NCAND);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

  // One result candidate decided by an accepted item.
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
  } cand_t;

  // Result queue status seen by the front end.
  typedef struct packed {
    logic can_accept;
  } rq_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbnf_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two mask rows per column: bit 1 is the row two back, bit 0 the row one back.
module sbnf_line_buf (
  input  logic           clk,
  input  logic           wr_en,
  input  sbnf_pkg::addr_t wr_addr,
  input  logic [1:0]     wr_data,
  input  sbnf_pkg::addr_t rd_addr,
  output logic [1:0]     rd_data
);

  logic [1:0] mem [sbnf_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbnf_result_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hold the candidates of one item and drain them, lowest slot first,
// through a single output register.
module sbnf_result_queue (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  input  sbnf_pkg::cand_t [sbnf_pkg::NCAND-1:0]    cands,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output sbnf_pkg::coord_t                         node_x,
  output sbnf_pkg::coord_t                         node_y,
  output logic                                     last,
  output sbnf_pkg::rq_status_t                     status
);

  sbnf_pkg::cand_t [sbnf_pkg::NCAND-1:0] slot;
  logic [sbnf_pkg::NCAND-1:0]            pv;
  logic [sbnf_pkg::NCAND-1:0]            sel;
  logic [sbnf_pkg::NCAND-1:0]            rest;
  logic [sbnf_pkg::NCAND-1:0]            push_mask;
  logic [sbnf_pkg::SLOT_W-1:0]           idx;
  logic                                  o_free;
  logic                                  move;

  always_comb begin
    idx = '0;
    for (int i = sbnf_pkg::NCAND - 1; i >= 0; i--) begin
      if (pv[i]) begin
        idx = sbnf_pkg::SLOT_W'(i);
      end
    end
    for (int i = 0; i < sbnf_pkg::NCAND; i++) begin
      push_mask[i] = cands[i].valid;
    end
  end

  assign sel    = pv & (~pv + sbnf_pkg::NCAND'(1));
  assign o_free = !result_valid || !result_stall;
  assign move   = o_free && (pv != '0);
  assign rest   = move ? (pv & ~sel) : pv;

  assign status.can_accept = (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv           <= '0;
      result_valid <= 1'b0;
    end else begin
      pv <= push ? push_mask : rest;
      if (move) begin
        result_valid <= 1'b1;
      end else if (o_free) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot <= cands;
    end
    if (move) begin
      node_x <= slot[idx].x;
      node_y <= slot[idx].y;
      last   <= (rest == '0);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/solid_border_node_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Solid border node finder.
// The item channel (item_valid, item_stall, solid) takes one mask bit per
// node in raster order, x fastest. A solid node with at least one fluid
// node among its 8 neighbors is reported on the result channel
// (result_valid, result_stall, node_x, node_y, last); nodes off the grid
// count as solid, and the west and east columns report only at corners.
// last marks the final result caused by one item.
// Throughput: one item per cycle while item_stall is low; the two mask rows
// above live in a one-port-read, one-port-write line buffer read at the
// next position, so no bubble is needed. The single output register sends
// one result per cycle while result_stall is low, so an item with several
// results holds the item channel while they drain (up to three at the end
// of the last row, two per item along it); each passes the queue slots first.
// Reset: grid 16 x 16, position (0, 0), no results pending; the line buffer
// needs no clearing since rows are always rewritten before they are read.
// A width or height write (cfg_valid, cfg_ready always high) restarts the
// grid at (0, 0); write only while idle. A stalled receiver holds the
// result and, once the pending results cannot drain, raises item_stall.
module solid_border_node_finder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              solid,
  output logic                              result_valid,
  input  logic                              result_stall,
  output sbnf_pkg::coord_t                  node_x,
  output sbnf_pkg::coord_t                  node_y,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbnf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbnf_pkg::DIM_W-1:0]        cfg_data
);

  // Clamp a dimension to [3, maxv] and return it minus one.
  function automatic sbnf_pkg::coord_t clamp_m1(input logic [sbnf_pkg::DIM_W-1:0] v,
                                                 input logic [sbnf_pkg::DIM_W-1:0] maxv);
    logic [sbnf_pkg::DIM_W-1:0] t;
    if (v < sbnf_pkg::DIM_W'(3)) begin
      t = sbnf_pkg::DIM_W'(2);
    end else if (v > maxv) begin
      t = maxv - sbnf_pkg::DIM_W'(1);
    end else begin
      t = v - sbnf_pkg::DIM_W'(1);
    end
    return t[sbnf_pkg::COORD_W-1:0];
  endfunction

  // Center solid and some node in the window fluid.
  function automatic logic is_border(input logic [8:0] w);
    return w[4] && (w != 9'h1FF);
  endfunction

  // Shift every column up by one row and put a solid row below.
  function automatic logic [8:0] bottom_view(input logic [8:0] w);
    logic [8:0] r;
    for (int c = 0; c < 3; c++) begin
      r[3*c]     = w[3*c+1];
      r[3*c + 1] = w[3*c+2];
      r[3*c + 2] = 1'b1;
    end
    return r;
  endfunction

  sbnf_pkg::coord_t wm1;
  sbnf_pkg::coord_t hm1;
  sbnf_pkg::coord_t col;
  sbnf_pkg::coord_t row;
  sbnf_pkg::coord_t col_next;
  sbnf_pkg::coord_t row_next;
  logic [8:0]       win;
  logic [8:0]       base;
  logic [8:0]       nw;
  logic [8:0]       edge_win;
  logic [1:0]       line_rd;
  logic             top_bit;
  logic             mid_bit;
  logic             at_end;
  logic             acc;
  logic             cfg_we;
  logic             cfg_hit;

  sbnf_pkg::cand_t [sbnf_pkg::NCAND-1:0] cands;
  sbnf_pkg::rq_status_t                  q_status;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_we &&
                     ((cfg_index == sbnf_pkg::REG_GRID_WIDTH) ||
                      (cfg_index == sbnf_pkg::REG_GRID_HEIGHT));

  assign item_stall = !q_status.can_accept;
  assign acc        = item_valid && !item_stall;

  // Grid size, stored clamped and minus one.
  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= sbnf_pkg::COORD_W'(15);
      hm1 <= sbnf_pkg::COORD_W'(15);
    end else if (cfg_we) begin
      unique case (sbnf_pkg::cfg_reg_t'(cfg_index))
        sbnf_pkg::REG_GRID_WIDTH: begin
          wm1 <= clamp_m1(cfg_data, sbnf_pkg::DIM_W'(sbnf_pkg::MAX_WIDTH));
        end
        sbnf_pkg::REG_GRID_HEIGHT: begin
          hm1 <= clamp_m1(cfg_data, sbnf_pkg::DIM_W'(sbnf_pkg::MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  assign at_end = (col == wm1);

  // Position of the next item; also the line buffer read address, so the
  // two rows above are ready when that item arrives.
  always_comb begin
    col_next = col;
    row_next = row;
    if (rst || cfg_hit) begin
      col_next = '0;
      row_next = '0;
    end else if (acc) begin
      if (at_end) begin
        col_next = '0;
        row_next = (row == hm1) ? '0 : row + sbnf_pkg::COORD_W'(1);
      end else begin
        col_next = col + sbnf_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Shift the row one back into the row-two-back slot, store the new bit.
  sbnf_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (col),
    .wr_data ({line_rd[0], solid}),
    .rd_addr (col_next),
    .rd_data (line_rd)
  );

  // Rows above the grid read as solid.
  assign top_bit  = (row > sbnf_pkg::COORD_W'(1)) ? line_rd[1] : 1'b1;
  assign mid_bit  = (row != '0) ? line_rd[0] : 1'b1;
  // Start every row with a solid column to the west.
  assign base     = (col == '0) ? 9'h1FF : win;
  assign nw       = {solid, mid_bit, top_bit, base[8:3]};
  assign edge_win = {3'b111, nw[8:3]};

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      win <= 9'h1FF;
    end else if (acc) begin
      win <= nw;
    end
  end

  // Candidates in raster order within the item: the node west of the
  // incoming column one row up, the east edge node one row up, then the
  // same two on the last row itself. Edge columns report only on the first
  // and last rows.
  always_comb begin
    cands[0].valid = (row != '0) && (col != '0) && is_border(nw) &&
                     ((col != sbnf_pkg::COORD_W'(1)) || (row == sbnf_pkg::COORD_W'(1)));
    cands[0].x     = col - sbnf_pkg::COORD_W'(1);
    cands[0].y     = row - sbnf_pkg::COORD_W'(1);

    cands[1].valid = (row == sbnf_pkg::COORD_W'(1)) && at_end && is_border(edge_win);
    cands[1].x     = col;
    cands[1].y     = row - sbnf_pkg::COORD_W'(1);

    cands[2].valid = (row == hm1) && (col != '0) && is_border(bottom_view(nw));
    cands[2].x     = col - sbnf_pkg::COORD_W'(1);
    cands[2].y     = row;

    cands[3].valid = (row == hm1) && at_end && is_border(bottom_view(edge_win));
    cands[3].x     = col;
    cands[3].y     = row;
  end

  sbnf_result_queue u_result_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (acc),
    .cands        (cands),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .node_x       (node_x),
    .node_y       (node_y),
    .last         (last),
    .status       (q_status)
  );

`include "solid_border_node_finder_macros.svh"

  `SBNF_ASSERT_NOW(a_pos_in_grid, 1'b1, (col <= wm1) && (row <= hm1), "position beyond grid")
  `SBNF_ASSERT_NEXT(a_col_step, acc && !cfg_hit && !at_end, col == $past(col) + 10'd1, "col stuck")
  `SBNF_ASSERT_NEXT(a_row_wrap, acc && !cfg_hit && at_end, col == '0, "column did not wrap at row end")

endmodule

`default_nettype wire
